>>> rtl/pds_pkg.sv
// Types, constants and helper functions shared by the derivative smoother.
`timescale 1ns / 1ps
`default_nettype none
package pds_pkg;

  localparam int NumVehicles = 16;
  localparam int MaxSpan = 16;
  localparam int VehW = $clog2(NumVehicles);
  localparam int SlotW = $clog2(MaxSpan);
  localparam int AxisW = 2;
  localparam int SpanW = 5;
  localparam int HistAddrW = VehW + SlotW + AxisW;
  localparam int StateAddrW = VehW + AxisW;
  localparam int DivNumW = 48;
  localparam int DivDenW = 32;

  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;

  localparam logic [0:0] RegVelocitySpan = 1'b0;
  localparam logic [0:0] RegAccelSpan = 1'b1;
  localparam logic [SpanW-1:0] SpanReset = 5'd10;

  typedef struct packed {
    logic [3:0] vehicle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0] elapsed;
  } sample_t;

  typedef struct packed {
    logic [3:0] vehicle_out;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic saturated;
  } result_t;

  typedef struct packed {
    logic sat;
    logic [31:0] val;
  } qval_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOAD,
    S_START,
    S_WAIT,
    S_POST,
    S_WRITE,
    S_OUT
  } seq_state_t;

  function automatic logic [SpanW-1:0] eff_span(input logic [SpanW-1:0] s);
    logic [SpanW-1:0] r;
    r = s;
    if (s == '0) begin
      r = SpanW'(1);
    end else if (s > SpanW'(MaxSpan)) begin
      r = SpanW'(MaxSpan);
    end
    return r;
  endfunction

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] slot,
                                                 input logic [SpanW-1:0] span);
    logic [SpanW-1:0] n;
    n = SpanW'(slot) + SpanW'(1);
    return (n >= span) ? '0 : n[SlotW-1:0];
  endfunction

  function automatic qval_t qfix(input logic neg, input logic zero, input logic dtz,
                                 input logic [DivNumW-1:0] q);
    qval_t r;
    r.sat = 1'b0;
    r.val = q[31:0];
    if (dtz) begin
      r.sat = 1'b1;
      r.val = zero ? 32'd0 : (neg ? QMin : QMax);
    end else if (neg) begin
      if (q > DivNumW'(33'h1_0000_0000 >> 1)) begin
        r.sat = 1'b1;
        r.val = QMin;
      end else begin
        r.val = 32'd0 - q[31:0];
      end
    end else if (q > DivNumW'(QMax)) begin
      r.sat = 1'b1;
      r.val = QMax;
    end
    return r;
  endfunction

  function automatic qval_t clamp34(input logic signed [33:0] t);
    qval_t r;
    r.sat = 1'b0;
    r.val = t[31:0];
    if (t > $signed({2'b00, QMax})) begin
      r.sat = 1'b1;
      r.val = QMax;
    end else if (t < $signed({2'b11, QMin})) begin
      r.sat = 1'b1;
      r.val = QMin;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pds_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pds_div
  import pds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DivNumW-1:0] dividend,
  input  wire logic [DivDenW-1:0] divisor,
  output logic                    done,
  output logic [DivNumW-1:0]      quotient
);

  localparam int CntW = $clog2(DivNumW + 1);

  logic [DivDenW-1:0] rem;
  logic [DivDenW-1:0] den;
  logic [CntW-1:0] cnt;
  logic run;
  logic [DivDenW:0] shifted;
  logic take;

  always_comb begin
    shifted = {rem, quotient[DivNumW-1]};
    take = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CntW'(DivNumW);
      end else if (run) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (run) begin
      quotient <= {quotient[DivNumW-2:0], take};
      rem <= take ? DivDenW'(shifted - {1'b0, den}) : shifted[DivDenW-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/position_derivative_smoother.sv
// Top level of the position derivative smoother: sequencer, state memories and result register.
// Each axis runs four 48-step divisions in the single shared divider, twelve per word.
// The next word is taken once the sequence for the current word ends.
// Reset: a clearing pass zeroes all state and history memories.
// Words are not accepted during the clearing pass; span writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module position_derivative_smoother
  import pds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  sample_stall,
  input  wire sample_t          sample,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result,
  input  wire logic             wr_en,
  input  wire logic [0:0]       wr_index,
  input  wire logic [SpanW-1:0] wr_data
);

  seq_state_t state, state_next;

  logic [SpanW-1:0] velocity_span, accel_span;
  logic [SpanW-1:0] vs, as_eff;

  sample_t item;
  logic [AxisW-1:0] axis;
  logic [1:0] phase;
  logic sat;

  logic [SlotW-1:0] velocity_slot [NumVehicles];
  logic [SlotW-1:0] accel_slot [NumVehicles];
  logic [SlotW-1:0] vslot, aslot;

  logic [95:0] state_mem [2**StateAddrW];
  logic [31:0] vhist_mem [2**HistAddrW];
  logic [31:0] ahist_mem [2**HistAddrW];
  logic [95:0] state_rd;
  logic [31:0] vhist_rd, ahist_rd;
  logic [StateAddrW-1:0] state_addr;
  logic [HistAddrW-1:0] vhist_addr, ahist_addr;
  logic state_we, hist_we;
  logic [95:0] state_wd;
  logic [31:0] vhist_wd, ahist_wd;
  logic [HistAddrW-1:0] clr_cnt;

  logic signed [31:0] prev, svo, sao, vh, ah;
  logic signed [31:0] vraw, vf, araw, af;
  logic signed [31:0] vel_r [3];
  logic signed [31:0] acc_r [3];

  logic num_neg, num_zero;
  logic signed [32:0] num;
  logic [31:0] mag;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic div_start, div_done;
  logic [DivNumW-1:0] div_q;
  logic signed [31:0] pos_sel;
  logic signed [32:0] q_signed;
  qval_t post_val;
  logic out_free;

  pds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign vs = eff_span(velocity_span);
  assign as_eff = eff_span(accel_span);
  assign vslot = velocity_slot[item.vehicle];
  assign aslot = accel_slot[item.vehicle];
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    unique case (axis)
      2'd0: pos_sel = item.pos_x;
      2'd1: pos_sel = item.pos_y;
      default: pos_sel = item.pos_z;
    endcase
  end

  always_comb begin
    unique case (phase)
      2'd0: num = {pos_sel[31], pos_sel} - {prev[31], prev};
      2'd1: num = {vh[31], vh} - {vraw[31], vraw};
      2'd2: num = {vf[31], vf} - {svo[31], svo};
      default: num = {ah[31], ah} - {araw[31], araw};
    endcase
    mag = num[32] ? 32'(-num) : num[31:0];
    if (phase[0]) begin
      div_num = {16'd0, mag};
      div_den = DivDenW'(phase == 2'd1 ? vs : as_eff);
    end else begin
      div_num = {mag, 16'd0};
      div_den = item.elapsed;
    end
  end

  always_comb begin
    q_signed = num_neg ? -$signed({1'b0, div_q[31:0]}) : $signed({1'b0, div_q[31:0]});
    unique case (phase)
      2'd1: post_val = clamp34({svo[31], svo[31], svo} - {q_signed[32], q_signed});
      2'd3: post_val = clamp34({sao[31], sao[31], sao} - {q_signed[32], q_signed});
      default: post_val = qfix(num_neg, num_zero, item.elapsed == '0, div_q);
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == '1) state_next = S_IDLE;
      S_IDLE: if (sample_valid) state_next = S_READ;
      S_READ: state_next = S_LOAD;
      S_LOAD: state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT: if (div_done) state_next = S_POST;
      S_POST: state_next = (phase == 2'd3) ? S_WRITE : S_START;
      S_WRITE: state_next = (axis == 2'd2) ? S_OUT : S_READ;
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    sample_stall = (state != S_IDLE);
    div_start = (state == S_START);
    state_we = 1'b0;
    hist_we = 1'b0;
    state_addr = {item.vehicle, axis};
    vhist_addr = {item.vehicle, vslot, axis};
    ahist_addr = {item.vehicle, aslot, axis};
    state_wd = {pos_sel, vf, af};
    vhist_wd = vraw;
    ahist_wd = araw;
    if (state == S_CLEAR) begin
      state_we = (clr_cnt[HistAddrW-1:StateAddrW] == '0);
      hist_we = 1'b1;
      state_addr = clr_cnt[StateAddrW-1:0];
      vhist_addr = clr_cnt;
      ahist_addr = clr_cnt;
      state_wd = '0;
      vhist_wd = '0;
      ahist_wd = '0;
    end else if (state == S_WRITE) begin
      state_we = 1'b1;
      hist_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_we) begin
      state_mem[state_addr] <= state_wd;
    end
    state_rd <= state_mem[state_addr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      vhist_mem[vhist_addr] <= vhist_wd;
    end
    vhist_rd <= vhist_mem[vhist_addr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      ahist_mem[ahist_addr] <= ahist_wd;
    end
    ahist_rd <= ahist_mem[ahist_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      velocity_span <= SpanReset;
      accel_span <= SpanReset;
      result_valid <= 1'b0;
      for (int i = 0; i < NumVehicles; i++) begin
        velocity_slot[i] <= '0;
        accel_slot[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + HistAddrW'(1);
      end
      if (wr_en) begin
        unique case (wr_index)
          RegVelocitySpan: velocity_span <= wr_data;
          default: accel_span <= wr_data;
        endcase
      end
      if (state == S_WRITE && axis == 2'd2) begin
        velocity_slot[item.vehicle] <= next_slot(vslot, vs);
        accel_slot[item.vehicle] <= next_slot(aslot, as_eff);
      end
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        item <= sample;
        axis <= '0;
        sat <= 1'b0;
      end
      S_LOAD: begin
        prev <= state_rd[95:64];
        svo <= state_rd[63:32];
        sao <= state_rd[31:0];
        vh <= vhist_rd;
        ah <= ahist_rd;
        phase <= '0;
      end
      S_START: begin
        num_neg <= num[32];
        num_zero <= (num == '0);
      end
      S_POST: begin
        sat <= sat | post_val.sat;
        phase <= phase + 2'd1;
        unique case (phase)
          2'd0: vraw <= post_val.val;
          2'd1: vf <= post_val.val;
          2'd2: araw <= post_val.val;
          default: af <= post_val.val;
        endcase
      end
      S_WRITE: begin
        vel_r[axis] <= vf;
        acc_r[axis] <= af;
        axis <= axis + 2'd1;
      end
      S_OUT: begin
        if (out_free) begin
          result.vehicle_out <= item.vehicle;
          result.vel_x <= vel_r[0];
          result.vel_y <= vel_r[1];
          result.vel_z <= vel_r[2];
          result.acc_x <= acc_r[0];
          result.acc_y <= acc_r[1];
          result.acc_z <= acc_r[2];
          result.saturated <= sat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/pds_checker.sv
// Port-level checks for the derivative smoother, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pds_assertions
  import pds_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    sample_valid,
  input wire logic    sample_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // The clearing pass keeps the input side closed right after reset.
  a_clear_stall: assert property (@(posedge clk) rst |=> sample_stall)
    else $error("input taken during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("second word taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> !$rose(result_valid))
    else $error("result appeared one cycle after accept");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

endmodule

bind position_derivative_smoother pds_assertions u_pds_assertions (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire

>>> dv/pds_checker.sv
// Checker for the derivative smoother: predicts each result word and compares it with the block.
`timescale 1ns / 1ps
module pds_checker
  import pds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  input  wire logic             sample_stall,
  input  wire sample_t          sample,
  input  wire logic             result_valid,
  input  wire logic             result_stall,
  input  wire result_t          result,
  input  wire logic             wr_en,
  input  wire logic [0:0]       wr_index,
  input  wire logic [SpanW-1:0] wr_data,
  output int                    errors,
  output int                    pending
);

  logic [SpanW-1:0] vel_span_reg;
  logic [SpanW-1:0] acc_span_reg;
  int prev_pos[NumVehicles][3];
  int vel_avg[NumVehicles][3];
  int acc_avg[NumVehicles][3];
  int vel_ring[NumVehicles][MaxSpan][3];
  int acc_ring[NumVehicles][MaxSpan][3];
  int vel_slot[NumVehicles];
  int acc_slot[NumVehicles];
  result_t expected_words[$];

  assign pending = expected_words.size();

  function automatic int span_in_use(input logic [SpanW-1:0] s);
    if (s == '0) return 1;
    if (s > SpanW'(MaxSpan)) return MaxSpan;
    return int'(s);
  endfunction

  function automatic logic [31:0] quotient_q(input longint num, input logic [31:0] den,
                                             inout logic sat);
    logic [63:0] mag;
    logic [63:0] q;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    if (den == 32'd0) begin
      sat = 1'b1;
      if (mag == 64'd0) return 32'd0;
      return neg ? QMin : QMax;
    end
    q = (mag << 16) / {32'd0, den};
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return QMin;
      end
      return 32'd0 - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return QMax;
    end
    return q[31:0];
  endfunction

  function automatic logic [31:0] clamp_q(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return QMax;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return QMin;
    end
    return v[31:0];
  endfunction

  task automatic predict_motion(input sample_t s);
    result_t r;
    logic sat;
    int v, vlen, alen, vs, as_slot, a;
    int pos[3];
    int vraw, vf, araw, af, vold;
    r = '0;
    sat = 1'b0;
    v = int'(s.vehicle);
    vlen = span_in_use(vel_span_reg);
    alen = span_in_use(acc_span_reg);
    vs = vel_slot[v] % MaxSpan;
    as_slot = acc_slot[v] % MaxSpan;
    pos[0] = s.pos_x;
    pos[1] = s.pos_y;
    pos[2] = s.pos_z;
    r.vehicle_out = s.vehicle;
    for (a = 0; a < 3; a++) begin
      vold = vel_avg[v][a];
      vraw = quotient_q(longint'(pos[a]) - longint'(prev_pos[v][a]), s.elapsed, sat);
      vf = clamp_q(longint'(vold) -
                   (longint'(vel_ring[v][vs][a]) - longint'(vraw)) / longint'(vlen), sat);
      araw = quotient_q(longint'(vf) - longint'(vold), s.elapsed, sat);
      af = clamp_q(longint'(acc_avg[v][a]) -
                   (longint'(acc_ring[v][as_slot][a]) - longint'(araw)) / longint'(alen), sat);
      prev_pos[v][a] = pos[a];
      vel_avg[v][a] = vf;
      acc_avg[v][a] = af;
      vel_ring[v][vs][a] = vraw;
      acc_ring[v][as_slot][a] = araw;
      case (a)
        0: begin r.vel_x = vf; r.acc_x = af; end
        1: begin r.vel_y = vf; r.acc_y = af; end
        default: begin r.vel_z = vf; r.acc_z = af; end
      endcase
    end
    vel_slot[v] = (vs + 1 >= vlen) ? 0 : vs + 1;
    acc_slot[v] = (as_slot + 1 >= alen) ? 0 : as_slot + 1;
    r.saturated = sat;
    expected_words.insert(expected_words.size(), r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s expected %h actual %h", name, exp, act);
      errors++;
    end
  endtask

  task automatic compare_word(input result_t got);
    result_t e;
    if (expected_words.size() == 0) begin
      $error("result word with no expected word, vehicle_out %h", got.vehicle_out);
      errors++;
      return;
    end
    e = expected_words.pop_front();
    check_field("vehicle_out", 32'(e.vehicle_out), 32'(got.vehicle_out));
    check_field("vel_x", e.vel_x, got.vel_x);
    check_field("vel_y", e.vel_y, got.vel_y);
    check_field("vel_z", e.vel_z, got.vel_z);
    check_field("acc_x", e.acc_x, got.acc_x);
    check_field("acc_y", e.acc_y, got.acc_y);
    check_field("acc_z", e.acc_z, got.acc_z);
    check_field("saturated", 32'(e.saturated), 32'(got.saturated));
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      vel_span_reg = SpanReset;
      acc_span_reg = SpanReset;
      foreach (prev_pos[i, j]) begin
        prev_pos[i][j] = 0;
        vel_avg[i][j] = 0;
        acc_avg[i][j] = 0;
      end
      foreach (vel_ring[i, k, j]) begin
        vel_ring[i][k][j] = 0;
        acc_ring[i][k][j] = 0;
      end
      foreach (vel_slot[i]) begin
        vel_slot[i] = 0;
        acc_slot[i] = 0;
      end
      expected_words.delete();
    end else begin
      if (result_valid && !result_stall) compare_word(result);
      if (sample_valid && !sample_stall) predict_motion(sample);
      if (wr_en) begin
        if (wr_index == RegVelocitySpan) vel_span_reg = wr_data;
        else acc_span_reg = wr_data;
      end
    end
  end

endmodule

>>> dv/position_derivative_smoother_tb.sv
// Testbench top for the derivative smoother: stimulus, span settings, idling and verdict.
`timescale 1ns / 1ps
module position_derivative_smoother_tb;
  import pds_pkg::*;

  localparam int CycleLimit = 4000000;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  sample_t sample;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic wr_en;
  logic [0:0] wr_index;
  logic [SpanW-1:0] wr_data;
  int errors;
  int pending;
  int cycles;
  int snd_idle;
  int rcv_idle;
  int track_pos[NumVehicles][3];
  int track_step[NumVehicles][3];

  position_derivative_smoother uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  pds_checker checker_i (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("position_derivative_smoother_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) result_stall <= ($urandom_range(99) < rcv_idle);

  task automatic send_word(input sample_t s);
    while ($urandom_range(99) < snd_idle) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = s;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
    sample_valid = 1'b0;
  endtask

  task automatic send_fields(input int v, input int x, input int y, input int z,
                             input logic [31:0] dt);
    sample_t s;
    s.vehicle = v[3:0];
    s.pos_x = x;
    s.pos_y = y;
    s.pos_z = z;
    s.elapsed = dt;
    send_word(s);
  endtask

  task automatic drain_and_set(input logic [SpanW-1:0] vspan, input logic [SpanW-1:0] aspan);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    wr_en = 1'b1;
    wr_index = RegVelocitySpan;
    wr_data = vspan;
    @(negedge clk);
    wr_index = RegAccelSpan;
    wr_data = aspan;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  function automatic logic [SpanW-1:0] pick_span();
    logic [SpanW-1:0] choices[9] = '{5'd0, 5'd1, 5'd2, 5'd5, 5'd10, 5'd15, 5'd16, 5'd17, 5'd31};
    return choices[$urandom_range(8)];
  endfunction

  task automatic random_word();
    sample_t s;
    int v, a;
    if ($urandom_range(99) < 10) begin
      s.vehicle = 4'($urandom);
      s.pos_x = $urandom;
      s.pos_y = $urandom;
      s.pos_z = $urandom;
      case ($urandom_range(3))
        0: s.elapsed = 32'd0;
        1: s.elapsed = $urandom_range(1, 16);
        default: s.elapsed = $urandom;
      endcase
    end else begin
      v = $urandom_range(NumVehicles - 1);
      for (a = 0; a < 3; a++) begin
        track_step[v][a] += int'($urandom_range(4000)) - 2000;
        track_pos[v][a] += track_step[v][a];
      end
      s.vehicle = v[3:0];
      s.pos_x = track_pos[v][0];
      s.pos_y = track_pos[v][1];
      s.pos_z = track_pos[v][2];
      s.elapsed = ($urandom_range(19) == 0) ? $urandom_range(65536, 1 << 22)
                                            : $urandom_range(300, 2000);
    end
    send_word(s);
  endtask

  initial begin
    int p, b, n;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    result_stall = 1'b0;
    wr_en = 1'b0;
    wr_index = RegVelocitySpan;
    wr_data = '0;
    snd_idle = 12;
    rcv_idle = 61;
    foreach (track_pos[i, j]) begin
      track_pos[i][j] = 0;
      track_step[i][j] = 0;
    end
    repeat (3) @(negedge clk);
    rst = 1'b0;

    send_fields(0, 32'h0001_0000, -32'sh0001_0000, 0, 32'h0001_0000);
    send_fields(0, 32'h0001_0000, -32'sh0001_0000, 0, 32'd0);
    send_fields(0, 32'h7FFF_FFFF, 32'h8000_0000, 5, 32'd0);
    send_fields(15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    send_fields(15, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    send_fields(15, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_fields(7, 32'h0000_4000, 32'h0000_8000, -32'sh0000_4000, 32'h0000_0100);
    send_fields(7, -32'sh0000_4000, 32'h0000_0000, 32'h0000_4000, 32'hFFFF_FFFF);
    drain_and_set(5'd0, 5'd31);
    for (n = 0; n < 5; n++)
      send_fields(3, n * 32'h0000_2000, -n * 32'h0000_1000, 32'h0001_0000 - n, 32'd655);
    drain_and_set(5'd16, 5'd1);
    for (n = 0; n < 5; n++)
      send_fields(3, n * 32'h0000_3000, n * 32'h0000_1000, n, 32'd655);
    drain_and_set(5'd17, 5'd2);
    for (n = 0; n < 4; n++)
      send_fields(3, -n * 32'h0000_3000, n, 32'h7FFF_0000, 32'd1000);

    for (p = 0; p < 3; p++) begin
      snd_idle = (p == 0) ? 12 : (p == 1) ? 61 : 0;
      rcv_idle = (p == 0) ? 61 : (p == 1) ? 12 : 0;
      for (b = 0; b < 3; b++) begin
        drain_and_set(pick_span(), pick_span());
        for (n = 0; n < 100; n++) random_word();
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (700) @(negedge clk);
    if (errors == 0) begin
      $display("position_derivative_smoother_tb: clean");
    end else begin
      $display("position_derivative_smoother_tb: errors");
    end
    $finish;
  end

endmodule

>>> position_derivative_smoother.f
rtl/pds_pkg.sv
rtl/pds_div.sv
rtl/position_derivative_smoother.sv
rtl/pds_checker.sv
dv/pds_checker.sv
dv/position_derivative_smoother_tb.sv
